/* src/cskd_pkg.sv */
// Shared types and constants for the CSI key sequence decoder.
package cskd_pkg;

  localparam logic [7:0] CSI_BYTE    = 8'h9B;
  localparam logic [7:0] CHAR_QUERY  = 8'h3F;  // '?'
  localparam logic [7:0] CHAR_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CHAR_AT     = 8'h40;  // '@'
  localparam logic [7:0] CHAR_TILDE  = 8'h7E;  // '~'
  localparam logic [7:0] CHAR_ZERO   = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE   = 8'h39;  // '9'
  localparam logic [7:0] CHAR_UA     = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UB     = 8'h42;  // 'B'
  localparam logic [7:0] CHAR_UC     = 8'h43;  // 'C'
  localparam logic [7:0] CHAR_UD     = 8'h44;  // 'D'
  localparam logic [7:0] CHAR_US     = 8'h53;  // 'S'
  localparam logic [7:0] CHAR_UT     = 8'h54;  // 'T'

  localparam logic [4:0] NUM_SAT     = 5'd20;

  // Special key indices
  localparam logic [7:0] K_UP     = 8'd0;
  localparam logic [7:0] K_DOWN   = 8'd1;
  localparam logic [7:0] K_LEFT   = 8'd2;
  localparam logic [7:0] K_RIGHT  = 8'd3;
  localparam logic [7:0] K_SUP    = 8'd4;
  localparam logic [7:0] K_SDOWN  = 8'd5;
  localparam logic [7:0] K_SLEFT  = 8'd6;
  localparam logic [7:0] K_SRIGHT = 8'd7;
  localparam logic [7:0] K_HELP   = 8'd8;
  localparam logic [7:0] K_F1     = 8'd12;
  localparam logic [7:0] K_LAST   = 8'd31;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CSI,
    PH_HELP,
    PH_SPACE,
    PH_NUMBER,
    PH_DROP
  } phase_t;

  typedef struct packed {
    logic       key_is_special;
    logic [7:0] key_code;
  } key_t;

endpackage

/* src/cskd_byte_if.sv */
// Byte input channel: valid/ready handshake with one console byte.
interface cskd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/cskd_key_if.sv */
// Key output channel: valid/ready handshake with one decoded key.
interface cskd_key_if;
  logic       valid;
  logic       ready;
  logic       key_is_special;
  logic [7:0] key_code;

  modport source (output valid, output key_is_special, output key_code, input ready);
  modport sink   (input valid, input key_is_special, input key_code, output ready);
endinterface

/* src/cskd_in_reg.sv */
// Input register stage: holds one received byte until the parser takes it.
module cskd_in_reg (
  input  logic       clk,
  input  logic       rst,
  cskd_byte_if.sink  rx,
  input  logic       advance,
  output logic       s1_valid,
  output logic [7:0] s1_byte
);

  // Take a new byte whenever the stage is empty or drains this cycle.
  assign rx.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      s1_byte <= rx.rx_byte;
    end
  end

endmodule

/* src/cskd_parser.sv */
// Sequence parser: phase machine and digit accumulator, one byte per cycle while advance is high.
module cskd_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  logic [7:0]    c,
  input  logic          fkey_decode_enable,
  output logic          res_valid,
  output cskd_pkg::key_t res
);

  cskd_pkg::phase_t phase, phase_next;
  logic [4:0]       number_value, number_next;

  logic       is_digit;
  logic [3:0] digit;
  logic [7:0] acc;

  assign is_digit = (c >= cskd_pkg::CHAR_ZERO) && (c <= cskd_pkg::CHAR_NINE);
  assign digit    = 4'(c - cskd_pkg::CHAR_ZERO);
  // 10 * value + digit, value never above the saturation limit
  assign acc = {number_value, 3'b000} + {2'b00, number_value, 1'b0} + {4'b0000, digit};

  // Next phase and accumulator
  always_comb begin
    phase_next  = cskd_pkg::PH_IDLE;
    number_next = number_value;
    unique case (phase)
      cskd_pkg::PH_CSI: begin
        if (c == cskd_pkg::CHAR_QUERY) begin
          phase_next = cskd_pkg::PH_HELP;
        end else if (c == cskd_pkg::CHAR_SPACE) begin
          phase_next = cskd_pkg::PH_SPACE;
        end else if (is_digit) begin
          phase_next  = cskd_pkg::PH_NUMBER;
          number_next = {1'b0, digit};
        end
      end
      cskd_pkg::PH_NUMBER: begin
        if (is_digit) begin
          phase_next  = cskd_pkg::PH_NUMBER;
          number_next = (acc > {3'b000, cskd_pkg::NUM_SAT}) ? cskd_pkg::NUM_SAT : acc[4:0];
        end
      end
      cskd_pkg::PH_IDLE: begin
        if (c == cskd_pkg::CSI_BYTE) begin
          phase_next = fkey_decode_enable ? cskd_pkg::PH_CSI : cskd_pkg::PH_DROP;
        end
      end
      default: begin
        phase_next = cskd_pkg::PH_IDLE;
      end
    endcase
  end

  // Result for the current byte
  always_comb begin
    res_valid          = 1'b0;
    res.key_is_special = 1'b1;
    res.key_code       = c;
    unique case (phase)
      cskd_pkg::PH_CSI: begin
        res_valid = 1'b1;
        unique case (c)
          cskd_pkg::CHAR_UA: res.key_code = cskd_pkg::K_UP;
          cskd_pkg::CHAR_UB: res.key_code = cskd_pkg::K_DOWN;
          cskd_pkg::CHAR_UC: res.key_code = cskd_pkg::K_RIGHT;
          cskd_pkg::CHAR_UD: res.key_code = cskd_pkg::K_LEFT;
          cskd_pkg::CHAR_UT: res.key_code = cskd_pkg::K_SUP;
          cskd_pkg::CHAR_US: res.key_code = cskd_pkg::K_SDOWN;
          default:           res_valid    = 1'b0;
        endcase
      end
      cskd_pkg::PH_HELP: begin
        res_valid    = 1'b1;
        res.key_code = cskd_pkg::K_HELP;
      end
      cskd_pkg::PH_SPACE: begin
        res_valid = 1'b1;
        unique case (c)
          cskd_pkg::CHAR_UA: res.key_code = cskd_pkg::K_SLEFT;
          cskd_pkg::CHAR_AT: res.key_code = cskd_pkg::K_SRIGHT;
          default:           res_valid    = 1'b0;
        endcase
      end
      cskd_pkg::PH_NUMBER: begin
        res_valid    = (c == cskd_pkg::CHAR_TILDE) && (number_value < cskd_pkg::NUM_SAT);
        res.key_code = cskd_pkg::K_F1 + {3'b000, number_value};
      end
      cskd_pkg::PH_DROP: begin
        res_valid = 1'b0;
      end
      default: begin
        res_valid          = (c != cskd_pkg::CSI_BYTE);
        res.key_is_special = 1'b0;
      end
    endcase
    res_valid = res_valid && advance;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= cskd_pkg::PH_IDLE;
      number_value <= 5'd0;
    end else if (advance) begin
      phase        <= phase_next;
      number_value <= number_next;
    end
  end

endmodule

/* src/cskd_out_reg.sv */
// Output register stage: holds one decoded key until the consumer takes it.
module cskd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  cskd_pkg::key_t res,
  output logic           can_load,
  cskd_key_if.source     key
);

  // Free when empty or when the held key leaves this cycle.
  assign can_load = !key.valid || key.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key.valid <= 1'b0;
    end else if (can_load) begin
      key.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      key.key_is_special <= res.key_is_special;
      key.key_code       <= res.key_code;
    end
  end

endmodule

/* src/csi_key_sequence_decoder.sv */
// Top level of the CSI key sequence decoder.
//
//   channel  dir  handshake        payload
//   rx       in   valid / ready    rx_byte[7:0]
//   key      out  valid / ready    key_is_special, key_code[7:0]
//   cfg      in   cfg_we           cfg_wdata (fkey_decode_enable)
//
// One byte per cycle sustained while key is ready. A byte accepted on rx is held in
// the input register, parsed, and its key is loaded into the output register,
// from which it leaves on key when key is ready.
// Bytes that end or continue a sequence without a key pass through the parser
// and leave nothing on key.
// rst is synchronous: phase goes idle, accumulator clears, decode enabled.
// A stall on key holds one key in the output register and one byte in the
// input register; rx drops ready only when both are full.
module csi_key_sequence_decoder (
  input  logic       clk,
  input  logic       rst,
  cskd_byte_if.sink  rx,
  cskd_key_if.source key,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic           fkey_decode_enable;
  logic           s1_valid;
  logic [7:0]     s1_byte;
  logic           can_load;
  logic           advance;
  logic           res_valid;
  cskd_pkg::key_t res;

  // Decode enable register; sampled by the parser only when CSI arrives.
  always_ff @(posedge clk) begin
    if (rst) begin
      fkey_decode_enable <= 1'b1;
    end else if (cfg_we) begin
      fkey_decode_enable <= cfg_wdata;
    end
  end

  // Advance the held byte through the parser whenever the output register
  // can take a result; bytes with no result advance under the same rule.
  assign advance = s1_valid && can_load;

  cskd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_byte  (s1_byte)
  );

  cskd_parser u_parser (
    .clk                (clk),
    .rst                (rst),
    .advance            (advance),
    .c                  (s1_byte),
    .fkey_decode_enable (fkey_decode_enable),
    .res_valid          (res_valid),
    .res                (res)
  );

  cskd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .can_load (can_load),
    .key      (key)
  );

  // A special key index is always one of the defined codes.
  a_special_code: assert property (@(posedge clk) disable iff (rst)
    key.valid && key.key_is_special |->
      (key.key_code <= cskd_pkg::K_HELP) ||
      ((key.key_code >= cskd_pkg::K_F1) && (key.key_code <= cskd_pkg::K_LAST)))
    else $error("special key index out of range");

  // CSI never leaves as a plain key.
  a_no_plain_csi: assert property (@(posedge clk) disable iff (rst)
    key.valid && !key.key_is_special |-> key.key_code != cskd_pkg::CSI_BYTE)
    else $error("CSI passed through as plain key");

  // A held byte stays in the input register while the output is blocked.
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !can_load |=> s1_valid && $stable(s1_byte))
    else $error("input byte lost during output stall");

  // Nothing is loaded into a full, stalled output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    key.valid && !key.ready |-> !res_valid)
    else $error("result produced into a stalled output register");

endmodule

/* test/csi_key_sequence_decoder_tb.sv */
// Self-checking testbench for the CSI key sequence decoder.
`timescale 1ns / 100ps

module csi_key_sequence_decoder_tb;

  localparam int HOLDOFF    = 6;    // settle time after the last owed key, before config writes
  localparam int LONG_HOLD  = 300;  // long key-side stall used to fill the block
  localparam int PHASES     = 5;
  localparam int PHASE_LEN  = 220;  // bytes per random phase
  localparam int DRAIN_MAX  = 5000;

  typedef logic [7:0] byte_q_t[$];

  // Tracks the decoder's parse state and holds the keys still owed on the key channel.
  class key_ledger;
    cskd_pkg::phase_t phase;
    logic [4:0]       num;
    logic             decode_en;
    cskd_pkg::key_t   owed_keys[$];
    int               errors;
    int               n_plain;
    int               n_special;
    int               n_fkey;

    function new();
      phase     = cskd_pkg::PH_IDLE;
      num       = '0;
      decode_en = 1'b1;
      errors    = 0;
      n_plain   = 0;
      n_special = 0;
      n_fkey    = 0;
    endfunction

    function void set_enable(logic v);
      decode_en = v;
    endfunction

    function int pending();
      return owed_keys.size();
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= cskd_pkg::CHAR_ZERO && c <= cskd_pkg::CHAR_NINE;
    endfunction

    function void queue_key(logic special, logic [7:0] code);
      cskd_pkg::key_t k;
      k.key_is_special = special;
      k.key_code       = code;
      owed_keys.push_back(k);
    endfunction

    // Advance the parse state by one accepted byte.
    function void note_byte(logic [7:0] c);
      cskd_pkg::phase_t ph;
      int               n;
      ph    = phase;
      phase = cskd_pkg::PH_IDLE;
      case (ph)
        cskd_pkg::PH_CSI: begin
          if (c == cskd_pkg::CHAR_QUERY)      phase = cskd_pkg::PH_HELP;
          else if (c == cskd_pkg::CHAR_SPACE) phase = cskd_pkg::PH_SPACE;
          else if (c == cskd_pkg::CHAR_UA)    queue_key(1'b1, cskd_pkg::K_UP);
          else if (c == cskd_pkg::CHAR_UB)    queue_key(1'b1, cskd_pkg::K_DOWN);
          else if (c == cskd_pkg::CHAR_UC)    queue_key(1'b1, cskd_pkg::K_RIGHT);
          else if (c == cskd_pkg::CHAR_UD)    queue_key(1'b1, cskd_pkg::K_LEFT);
          else if (c == cskd_pkg::CHAR_UT)    queue_key(1'b1, cskd_pkg::K_SUP);
          else if (c == cskd_pkg::CHAR_US)    queue_key(1'b1, cskd_pkg::K_SDOWN);
          else if (is_digit(c)) begin
            num   = 5'(c - cskd_pkg::CHAR_ZERO);
            phase = cskd_pkg::PH_NUMBER;
          end
        end
        cskd_pkg::PH_HELP: queue_key(1'b1, cskd_pkg::K_HELP);
        cskd_pkg::PH_SPACE: begin
          if (c == cskd_pkg::CHAR_UA)      queue_key(1'b1, cskd_pkg::K_SLEFT);
          else if (c == cskd_pkg::CHAR_AT) queue_key(1'b1, cskd_pkg::K_SRIGHT);
        end
        cskd_pkg::PH_NUMBER: begin
          if (is_digit(c)) begin
            n = 10 * int'(num) + int'(c - cskd_pkg::CHAR_ZERO);
            if (n > int'(cskd_pkg::NUM_SAT)) n = int'(cskd_pkg::NUM_SAT);
            num   = 5'(n);
            phase = cskd_pkg::PH_NUMBER;
          end else if (c == cskd_pkg::CHAR_TILDE && num < cskd_pkg::NUM_SAT) begin
            queue_key(1'b1, 8'(cskd_pkg::K_F1 + num));
          end
        end
        cskd_pkg::PH_DROP: ;
        default: begin
          if (c == cskd_pkg::CSI_BYTE)
            phase = decode_en ? cskd_pkg::PH_CSI : cskd_pkg::PH_DROP;
          else queue_key(1'b0, c);
        end
      endcase
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_key(logic special, logic [7:0] code);
      cskd_pkg::key_t want;
      if (owed_keys.size() == 0) begin
        report($sformatf("unexpected key special=%0b code=%0d", special, code));
      end else begin
        want = owed_keys.pop_front();
        if (special !== want.key_is_special || code !== want.key_code)
          report($sformatf("key special=%0b code=%0d, wanted special=%0b code=%0d",
                           special, code, want.key_is_special, want.key_code));
        if (want.key_is_special) begin
          n_special++;
          if (want.key_code >= cskd_pkg::K_F1) n_fkey++;
        end else begin
          n_plain++;
        end
      end
    endtask
  endclass

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;

  cskd_byte_if rx_ch ();
  cskd_key_if  key_ch ();

  key_ledger ledger = new();

  // Knobs shared between the byte sender and the key sink.
  bit sink_gaps     = 1'b0;
  bit src_gaps      = 1'b0;
  bit hold_keys_req = 1'b0;
  int bytes_sent    = 0;
  int cfg_writes    = 0;
  byte_q_t seq_bytes;

  csi_key_sequence_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .key       (key_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Note every accepted byte; values read here are the pre-edge ones.
  always @(posedge clk) begin
    if (!rst && rx_ch.valid && rx_ch.ready) ledger.note_byte(rx_ch.rx_byte);
  end

  // Check every accepted key against the oldest owed one.
  always @(posedge clk) begin
    if (!rst && key_ch.valid && key_ch.ready)
      ledger.check_key(key_ch.key_is_special, key_ch.key_code);
  end

  // Key sink: mostly ready, random stall bursts, and one long hold on request.
  initial begin
    key_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_keys_req) begin
        // count the long hold here so the sender keeps pushing into a full block
        key_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_keys_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
        key_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        key_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte and hold it until the block takes it.
  task send_byte(logic [7:0] b);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task idle_rx(int n);
    rx_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Drop valid, wait for every owed key, then let any keyless byte clear the pipe.
  task wait_drained();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (HOLDOFF) @(posedge clk);
  endtask

  task write_enable(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ledger.set_enable(v);
    cfg_writes++;
  endtask

  // Send the queued sequence, with random source gaps between bytes.
  task send_seq();
    foreach (seq_bytes[i]) begin
      if (src_gaps && $urandom_range(0, 9) == 0) idle_rx($urandom_range(1, 19));
      send_byte(seq_bytes[i]);
    end
  endtask

  // Append a decimal number; mostly in the F-key range, sometimes long enough to saturate.
  task add_number();
    int v;
    int nd;
    if ($urandom_range(0, 3) != 0) begin
      v = $urandom_range(0, 19);
      if (v >= 10) seq_bytes.push_back(8'(cskd_pkg::CHAR_ZERO + v / 10));
      else if ($urandom_range(0, 3) == 0) seq_bytes.push_back(cskd_pkg::CHAR_ZERO);
      seq_bytes.push_back(8'(cskd_pkg::CHAR_ZERO + v % 10));
    end else begin
      nd = $urandom_range(1, 4);
      repeat (nd) seq_bytes.push_back(8'(cskd_pkg::CHAR_ZERO + $urandom_range(0, 9)));
    end
  endtask

  // Build one random sequence: mostly well-formed CSI sequences, some noise and breakage.
  task build_seq();
    int pick;
    seq_bytes.delete();
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      seq_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 85) begin
      seq_bytes.push_back(cskd_pkg::CSI_BYTE);
      case ($urandom_range(0, 4))
        0: begin
          case ($urandom_range(0, 5))
            0: seq_bytes.push_back(cskd_pkg::CHAR_UA);
            1: seq_bytes.push_back(cskd_pkg::CHAR_UB);
            2: seq_bytes.push_back(cskd_pkg::CHAR_UC);
            3: seq_bytes.push_back(cskd_pkg::CHAR_UD);
            4: seq_bytes.push_back(cskd_pkg::CHAR_UT);
            default: seq_bytes.push_back(cskd_pkg::CHAR_US);
          endcase
        end
        1: begin
          seq_bytes.push_back(cskd_pkg::CHAR_QUERY);
          seq_bytes.push_back(8'($urandom_range(0, 255)));
        end
        2: begin
          seq_bytes.push_back(cskd_pkg::CHAR_SPACE);
          seq_bytes.push_back($urandom_range(0, 1) ? cskd_pkg::CHAR_UA : cskd_pkg::CHAR_AT);
        end
        default: begin
          add_number();
          seq_bytes.push_back(cskd_pkg::CHAR_TILDE);
        end
      endcase
    end else begin
      // broken sequences: junk after CSI, after space, or as a number terminator, or CSI after CSI
      seq_bytes.push_back(cskd_pkg::CSI_BYTE);
      case ($urandom_range(0, 3))
        0: seq_bytes.push_back(8'($urandom_range(0, 255)));
        1: begin
          seq_bytes.push_back(cskd_pkg::CHAR_SPACE);
          seq_bytes.push_back(8'($urandom_range(0, 255)));
        end
        2: begin
          add_number();
          seq_bytes.push_back(8'($urandom_range(0, 255)));
        end
        default: seq_bytes.push_back(cskd_pkg::CSI_BYTE);
      endcase
    end
  endtask

  initial begin
    int             phase_end;
    int             n;
    cskd_pkg::key_t missing;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'h00;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_enable(1'b1);

    // Directed: byte extremes, arrows and shifted arrows, help with a CSI as the
    // ignored byte, space forms good and bad, F-key number 19, saturated number, CSI after CSI.
    seq_bytes = '{8'h00, 8'hFF,
                  cskd_pkg::CSI_BYTE, cskd_pkg::CHAR_UA,
                  cskd_pkg::CSI_BYTE, cskd_pkg::CHAR_UT,
                  cskd_pkg::CSI_BYTE, cskd_pkg::CHAR_QUERY, cskd_pkg::CSI_BYTE,
                  cskd_pkg::CSI_BYTE, cskd_pkg::CHAR_SPACE, cskd_pkg::CHAR_AT,
                  cskd_pkg::CSI_BYTE, cskd_pkg::CHAR_SPACE, 8'h58,
                  cskd_pkg::CSI_BYTE, 8'h31, cskd_pkg::CHAR_NINE, cskd_pkg::CHAR_TILDE,
                  cskd_pkg::CSI_BYTE, 8'h32, 8'h35, cskd_pkg::CHAR_TILDE,
                  cskd_pkg::CSI_BYTE, cskd_pkg::CSI_BYTE};
    send_seq();
    wait_drained();

    // Random phases; decode enable alternates, the last phase runs with no idling.
    for (int p = 0; p < PHASES; p++) begin
      write_enable(p % 2 == 0);
      src_gaps  = (p != PHASES - 1) && (p != 1);
      sink_gaps = (p != PHASES - 1);
      phase_end = bytes_sent + PHASE_LEN;
      if (p == 2) hold_keys_req = 1'b1;
      while (bytes_sent < phase_end) begin
        build_seq();
        send_seq();
      end
      // make sure the sender pauses until every owed key is out
      wait_drained();
    end

    n = 0;
    while (ledger.pending() != 0 && n < DRAIN_MAX) begin
      @(posedge clk);
      n++;
    end
    repeat (HOLDOFF) @(posedge clk);
    while (ledger.pending() != 0) begin
      missing = ledger.owed_keys.pop_front();
      ledger.report($sformatf("key never arrived, code=%0d", missing.key_code));
    end

    $display("covered %0d bytes over %0d enable writes, with stalls and one long key hold",
             bytes_sent, cfg_writes);
    $display("keys checked: %0d plain, %0d special (%0d function keys)",
             ledger.n_plain, ledger.n_special, ledger.n_fkey);
    if (ledger.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("timeout");
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
